FILE: rtl/ternary_dot_product_core_macros.svh
// Assertion macros shared by the RTL of the ternary dot product core.
// Each macro expects clk, and TDP_ASSERT also rst_n, to be visible where it is used.
`ifndef TERNARY_DOT_PRODUCT_CORE_MACROS_SVH
`define TERNARY_DOT_PRODUCT_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked property, ignored while reset is asserted.
`define TDP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tdp assertion failed");
// Checked property, also evaluated during reset.
`define TDP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tdp assertion failed");
`else
`define TDP_ASSERT(lbl, prop)
`define TDP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: rtl/tdp_pkg.sv
`default_nettype none
package tdp_pkg;

  // Default geometry of the core.
  localparam int LANES_DEF    = 32;
  localparam int SUM_BITS_DEF = 25;

  // Lanes summed together in the first stage of the merge tree.
  localparam int GRP = 8;

  // Control that travels alongside each word through the pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } tdp_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/ternary_dot_product_core.sv
// Ternary dot product core.
// Input words arrive on the in_ stream, one chunk of up to LANES ternary
// elements per word, each vector held as a plus and a minus bit-plane.
// in_tlast marks the final chunk of a vector pair. On that chunk the core
// sends one word on the out_ stream: the saturated dot product in out_tdata
// and, in out_tuser, a flag that the running sum was clamped during the pair.
// The core takes one word per cycle while in_tready is high. A last chunk
// enters the stage A register of the merge tree at the accepting edge,
// moves on to stage B, and the saturating accumulator then loads the
// output register that drives out_tvalid.
// While a result waits on a stalled receiver, chunks without in_tlast keep
// flowing; a further last chunk waits in the pipeline and in_tready drops
// once all stages are full.
// Reset (rst_n low at a clock edge) empties the pipeline, clears the running
// sum and the saturation flag and drops out_tvalid.
`default_nettype none
module ternary_dot_product_core #(
  parameter int LANES    = tdp_pkg::LANES_DEF,
  parameter int SUM_BITS = tdp_pkg::SUM_BITS_DEF,
  parameter int CW       = $clog2(LANES + 1),
  parameter int IN_W     = ((4 * LANES + CW + 7) / 8) * 8,
  parameter int OUT_W    = ((SUM_BITS + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // a_plus, a_minus, b_plus, b_minus, lane_count, zero fill
  input  wire logic [IN_W-1:0]  in_tdata,
  input  wire logic             in_tlast,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // dot_value, zero fill
  output logic [OUT_W-1:0]      out_tdata,
  // saturated
  output logic                  out_tuser
);
  import tdp_pkg::*;

  localparam int SW = SUM_BITS;
  localparam int DW = $clog2(((LANES + GRP - 1) / GRP) * GRP + 1) + 1;
  localparam logic [SW:0] BOUND  = {2'b00, {(SW-1){1'b1}}};
  localparam logic [SW:0] NBOUND = ~BOUND + 1'b1;

  logic [LANES-1:0]       a_plus;
  logic [LANES-1:0]       a_minus;
  logic [LANES-1:0]       b_plus;
  logic [LANES-1:0]       b_minus;
  logic [CW-1:0]          lane_count;
  logic [LANES-1:0][1:0]  lane_prod;
  tdp_ctl_t               in_ctl;
  tdp_ctl_t               acc_ctl;
  logic signed [DW-1:0]   delta;
  logic                   acc_take;
  logic                   acc_last;
  logic [SW:0]            sum_ext;
  logic                   over_hi;
  logic                   over_lo;
  logic [SW-1:0]          sum_sat;
  logic [SW-1:0]          sum_r;
  logic [SW-1:0]          sum_nxt;
  logic                   ovf_r;
  logic                   ovf_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [SW-1:0]          dot_r;
  logic                   sat_r;

  // Unpack the input word.
  assign a_plus     = in_tdata[LANES-1:0];
  assign a_minus    = in_tdata[2*LANES-1:LANES];
  assign b_plus     = in_tdata[3*LANES-1:2*LANES];
  assign b_minus    = in_tdata[4*LANES-1:3*LANES];
  assign lane_count = in_tdata[4*LANES+CW-1:4*LANES];

  assign in_ctl.valid = in_tvalid;
  assign in_ctl.last  = in_tlast;

  // One ternary multiplier per lane.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    tdp_lane #(
      .LANE_IDX (i),
      .CW       (CW)
    ) u_lane (
      .a_p  (a_plus[i]),
      .a_m  (a_minus[i]),
      .b_p  (b_plus[i]),
      .b_m  (b_minus[i]),
      .cnt  (lane_count),
      .prod (lane_prod[i])
    );
  end

  // Registered adder tree over the lane products.
  tdp_merge #(
    .LANES (LANES),
    .DW    (DW)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .lane_prod (lane_prod),
    .in_ctl    (in_ctl),
    .in_rdy    (in_tready),
    .take      (acc_take),
    .out_ctl   (acc_ctl),
    .delta     (delta)
  );

  // A last chunk is only taken when the output register can accept its result.
  assign acc_take = acc_ctl.valid && (!acc_ctl.last || !out_valid_r || out_tready);
  assign acc_last = acc_take && acc_ctl.last;

  // Add the chunk total and clamp to the symmetric bound.
  assign sum_ext = {sum_r[SW-1], sum_r} + {{(SW+1-DW){delta[DW-1]}}, delta};
  assign over_hi = $signed(sum_ext) > $signed(BOUND);
  assign over_lo = $signed(sum_ext) < $signed(NBOUND);

  always_comb begin
    priority if (over_hi) begin
      sum_sat = BOUND[SW-1:0];
    end else if (over_lo) begin
      sum_sat = NBOUND[SW-1:0];
    end else begin
      sum_sat = sum_ext[SW-1:0];
    end
  end

  // Running state: updated per chunk, cleared after a last chunk.
  always_comb begin
    sum_nxt = sum_r;
    ovf_nxt = ovf_r;
    if (acc_take) begin
      if (acc_ctl.last) begin
        sum_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        sum_nxt = sum_sat;
        ovf_nxt = ovf_r | over_hi | over_lo;
      end
    end
  end

  // Output register handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (acc_last) begin
      dot_r <= sum_sat;
      sat_r <= ovf_r | over_hi | over_lo;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(dot_r);
  assign out_tuser  = sat_r;

`include "ternary_dot_product_core_macros.svh"

  // The most negative code is never reached by a clamped sum.
  `TDP_ASSERT(a_sum_in_range, sum_r != {1'b1, {(SW-1){1'b0}}})
  // State is clear after a vector pair finishes.
  `TDP_ASSERT(a_clear_after_last, acc_last |=> (sum_r == '0) && !ovf_r)
  // A new result appears only from a last chunk taken in the cycle before.
  `TDP_ASSERT(a_rise_from_last, $rose(out_valid_r) |-> $past(acc_last))
  // A result is never overwritten while the receiver stalls.
  `TDP_ASSERT(a_no_overwrite, !(acc_last && out_valid_r && !out_tready))
  // Reset leaves the output channel idle.
  `TDP_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid_r)

endmodule
`default_nettype wire

FILE: rtl/tdp_lane.sv
`default_nettype none
module tdp_lane #(
  parameter int LANE_IDX = 0,
  parameter int CW       = 6
) (
  input  wire logic          a_p,
  input  wire logic          a_m,
  input  wire logic          b_p,
  input  wire logic          b_m,
  input  wire logic [CW-1:0] cnt,
  output logic signed [1:0]  prod
);
  import tdp_pkg::*;

  logic en;
  logic a_nz;
  logic b_nz;

  // A lane takes part only below the word's lane count.
  assign en   = (cnt > CW'(LANE_IDX));
  assign a_nz = a_p ^ a_m;
  assign b_nz = b_p ^ b_m;

  // Product of two ternary digits: zero, plus one on equal signs, minus one otherwise.
  always_comb begin
    if (en && a_nz && b_nz) begin
      prod = (a_p == b_p) ? 2'sb01 : 2'sb11;
    end else begin
      prod = 2'sb00;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tdp_merge.sv
`default_nettype none
module tdp_merge #(
  parameter int LANES = tdp_pkg::LANES_DEF,
  parameter int DW    = 6
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [LANES-1:0][1:0]  lane_prod,
  input  wire tdp_pkg::tdp_ctl_t      in_ctl,
  output logic                        in_rdy,
  input  wire logic                   take,
  output tdp_pkg::tdp_ctl_t           out_ctl,
  output logic signed [DW-1:0]        delta
);
  import tdp_pkg::*;

  localparam int NGROUPS = (LANES + GRP - 1) / GRP;
  localparam int NPAD    = NGROUPS * GRP;
  localparam int GW      = $clog2(GRP + 1) + 1;

  logic [NPAD-1:0][1:0]         prod_pad;
  logic [NGROUPS-1:0][GW-1:0]   grp_nxt;
  logic [NGROUPS-1:0][GW-1:0]   grp_r;
  tdp_ctl_t                     ctl_a_r;
  tdp_ctl_t                     ctl_b_r;
  logic [DW-1:0]                delta_nxt;
  logic [DW-1:0]                delta_r;
  logic                         b_free;
  logic                         a_free;

  // Stage B frees up when it is empty or the accumulator takes its word.
  assign b_free = !ctl_b_r.valid || take;
  assign a_free = !ctl_a_r.valid || b_free;
  assign in_rdy = a_free;

  // Pad the lane products out to whole groups.
  always_comb begin
    prod_pad = '0;
    for (int i = 0; i < LANES; i++) begin
      prod_pad[i] = lane_prod[i];
    end
  end

  // First tree level: one small sum per group of lanes.
  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        grp_nxt[g] = grp_nxt[g]
                   + {{(GW-2){prod_pad[g*GRP+k][1]}}, prod_pad[g*GRP+k]};
      end
    end
  end

  // Second tree level: the group sums combine into the chunk total.
  always_comb begin
    delta_nxt = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      delta_nxt = delta_nxt + {{(DW-GW){grp_r[g][GW-1]}}, grp_r[g]};
    end
  end

  // Stage A registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
    end else if (a_free) begin
      ctl_a_r <= in_ctl;
    end
    if (a_free) begin
      grp_r <= grp_nxt;
    end
  end

  // Stage B registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
    end else if (b_free) begin
      ctl_b_r <= ctl_a_r;
    end
    if (b_free) begin
      delta_r <= delta_nxt;
    end
  end

  assign out_ctl = ctl_b_r;
  assign delta   = $signed(delta_r);

endmodule
`default_nettype wire

FILE: test/tdp_checker.sv
`timescale 1ns / 100ps
// Watches both streams of the ternary dot product core.
// It keeps its own running sum per vector pair and checks every result word.
module tdp_checker #(
  parameter int LANES    = tdp_pkg::LANES_DEF,
  parameter int SUM_BITS = tdp_pkg::SUM_BITS_DEF,
  parameter int CW       = $clog2(LANES + 1),
  parameter int IN_W     = ((4 * LANES + CW + 7) / 8) * 8,
  parameter int OUT_W    = ((SUM_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tlast,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  input  logic             out_tuser,
  output int               mismatches,
  output int               pending,
  output int               checked
);

  // Largest magnitude the running sum may hold.
  localparam longint SUM_LIMIT = (longint'(1) << (SUM_BITS - 1)) - 1;

  typedef struct packed {
    logic [SUM_BITS-1:0] dot_value;
    logic                saturated;
  } dot_result_t;

  dot_result_t expected_dots[$];
  longint      dot_sum = 0;
  logic        clamp_seen = 1'b0;
  int          fail_count = 0;
  int          check_count = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
    checked    = 0;
  end

  // Signed contribution of one chunk: agreeing lanes add one, opposing lanes
  // subtract one. Each of the four coincidence counts is taken on its own.
  function automatic int chunk_contribution(input logic [IN_W-1:0] word);
    logic [LANES-1:0] a_pos, a_neg, b_pos, b_neg, lane_mask;
    int unsigned      lanes;
    a_pos = word[0 * LANES +: LANES];
    a_neg = word[1 * LANES +: LANES];
    b_pos = word[2 * LANES +: LANES];
    b_neg = word[3 * LANES +: LANES];
    lanes = word[4 * LANES +: CW];
    if (lanes > LANES) lanes = LANES;
    lane_mask = '1;
    if (lanes < LANES) lane_mask = lane_mask >> (LANES - lanes);
    a_pos &= lane_mask;
    a_neg &= lane_mask;
    b_pos &= lane_mask;
    b_neg &= lane_mask;
    return $countones(a_pos & b_pos) + $countones(a_neg & b_neg)
         - $countones(a_pos & b_neg) - $countones(a_neg & b_pos);
  endfunction

  always @(posedge clk) begin : monitor
    dot_result_t want;
    if (!rst_n) begin
      dot_sum    = 0;
      clamp_seen = 1'b0;
      expected_dots.delete();
    end else begin
      // Result words are compared first; none can belong to a chunk taken
      // at the same edge.
      if (out_tvalid && out_tready) begin
        if (expected_dots.size() == 0) begin
          fail_count++;
          $display("%0t: result word with nothing expected: dot %0d saturated %0b",
                   $time, $signed(out_tdata[SUM_BITS-1:0]), out_tuser);
        end else begin
          want = expected_dots.pop_front();
          check_count++;
          if (out_tdata[SUM_BITS-1:0] !== want.dot_value) begin
            fail_count++;
            $display("%0t: dot value expected %0d, got %0d", $time,
                     $signed(want.dot_value), $signed(out_tdata[SUM_BITS-1:0]));
          end
          if (out_tuser !== want.saturated) begin
            fail_count++;
            $display("%0t: saturation flag expected %0b, got %0b", $time,
                     want.saturated, out_tuser);
          end
        end
      end

      // Accumulate the accepted chunk with symmetric clamping.
      if (in_tvalid && in_tready) begin
        dot_sum = dot_sum + chunk_contribution(in_tdata);
        if (dot_sum > SUM_LIMIT) begin
          dot_sum    = SUM_LIMIT;
          clamp_seen = 1'b1;
        end else if (dot_sum < -SUM_LIMIT) begin
          dot_sum    = -SUM_LIMIT;
          clamp_seen = 1'b1;
        end
        if (in_tlast) begin
          want.dot_value = dot_sum[SUM_BITS-1:0];
          want.saturated = clamp_seen;
          expected_dots.push_back(want);
          dot_sum    = 0;
          clamp_seen = 1'b0;
        end
      end
    end
    mismatches <= fail_count;
    pending    <= expected_dots.size();
    checked    <= check_count;
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
module tb;

  localparam int LANES          = tdp_pkg::LANES_DEF;
  localparam int SUM_BITS       = tdp_pkg::SUM_BITS_DEF;
  localparam int CW             = $clog2(LANES + 1);
  localparam int IN_W           = ((4 * LANES + CW + 7) / 8) * 8;
  localparam int OUT_W          = ((SUM_BITS + 7) / 8) * 8;
  localparam int RANDOM_CHUNKS  = 1400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam logic [LANES-1:0] ONES = '1;
  localparam logic [CW-1:0]    ALL_LANES = CW'(LANES);

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_pattern_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic            in_tlast = 1'b0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic            out_tuser;

  int mismatches;
  int pending_dots;
  int dots_checked;
  int chunks_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  ternary_dot_product_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  tdp_checker #(
    .LANES    (LANES),
    .SUM_BITS (SUM_BITS),
    .CW       (CW),
    .IN_W     (IN_W),
    .OUT_W    (OUT_W)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .pending    (pending_dots),
    .checked    (dots_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver readiness follows a randomly chosen pattern, picked anew whenever the current one runs out.
  rx_pattern_t rx_pattern = RX_OPEN;
  int          rx_left = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_t'($urandom_range(0, 3));
      rx_left    = $urandom_range(16, 160);
    end
    rx_left = rx_left - 1;
    case (rx_pattern)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      default:   out_tready <= (rx_left % 12 == 0);
    endcase
  end

  // End the run if no word moves on either stream for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one chunk and hold it until the core takes it. Between bursts the
  // sender drops in_tvalid for a random gap.
  task automatic send_chunk(input logic [LANES-1:0] a_pos, a_neg, b_pos, b_neg,
                            input logic [CW-1:0] lanes, input logic last);
    int gap;
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    in_tdata  = {{(IN_W - 4 * LANES - CW){1'b0}}, lanes, b_neg, b_pos, a_neg, a_pos};
    in_tlast  = last;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    chunks_sent++;
  endtask

  // One ternary vector chunk: mostly well formed, sometimes with both bits
  // of an element set, sparse, or made of solid planes.
  task automatic random_planes(output logic [LANES-1:0] pos, neg);
    int shape;
    shape = $urandom_range(0, 9);
    pos = $urandom;
    neg = $urandom;
    if (shape < 6) begin
      neg = neg & ~pos;
    end else if (shape == 7) begin
      pos = pos & $urandom & $urandom;
      neg = neg & $urandom & $urandom & ~pos;
    end else if (shape >= 8) begin
      pos = ($urandom_range(0, 1) == 1) ? ONES : '0;
      neg = ($urandom_range(0, 1) == 1) ? ONES : '0;
    end
  endtask

  initial begin : stimulus
    logic [LANES-1:0] a_pos, a_neg, b_pos, b_neg;
    logic [CW-1:0]    lanes;
    int               pair_len;
    int               random_sent;
    int               pick;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed chunks: each coincidence kind, elements with both bits set,
    // lane counts of zero, one, partial and above the lane total.
    send_chunk('0, '0, '0, '0, ALL_LANES, 1'b1);
    send_chunk(ONES, '0, ONES, '0, ALL_LANES, 1'b1);
    send_chunk('0, ONES, '0, ONES, ALL_LANES, 1'b1);
    send_chunk(ONES, '0, '0, ONES, ALL_LANES, 1'b1);
    send_chunk('0, ONES, ONES, '0, ALL_LANES, 1'b1);
    send_chunk(ONES, ONES, ONES, ONES, ALL_LANES, 1'b1);
    send_chunk(ONES, ONES, ONES, '0, ALL_LANES, 1'b1);
    send_chunk(ONES, '0, ONES, '0, '0, 1'b1);
    send_chunk(ONES, '0, ONES, '0, CW'(63), 1'b1);
    send_chunk(ONES, '0, ONES, '0, CW'(LANES + 1), 1'b1);
    send_chunk(ONES, '0, ONES, '0, CW'(1), 1'b1);
    send_chunk(ONES, '0, '0, ONES, CW'(LANES - 1), 1'b1);
    send_chunk(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, ALL_LANES, 1'b1);
    send_chunk(32'hAAAAAAAA, 32'h55555555, 32'h55555555, 32'hAAAAAAAA, ALL_LANES, 1'b1);
    // A pair spread over several chunks, one of them with no valid lanes.
    send_chunk(ONES, '0, ONES, '0, ALL_LANES, 1'b0);
    send_chunk(32'h0000000F, '0, '0, 32'h0000000F, ALL_LANES, 1'b0);
    send_chunk(32'h80000001, '0, 32'h80000001, '0, '0, 1'b0);
    send_chunk('0, 32'h80000001, 32'h80000001, ONES, ALL_LANES, 1'b1);

    // Random pairs, mostly short, some long.
    random_sent = 0;
    while (random_sent < RANDOM_CHUNKS) begin
      pair_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                              : $urandom_range(1, 5);
      for (int k = 0; k < pair_len; k++) begin
        random_planes(a_pos, a_neg);
        random_planes(b_pos, b_neg);
        pick = $urandom_range(0, 19);
        if (pick < 13)       lanes = ALL_LANES;
        else if (pick < 17)  lanes = CW'($urandom_range(1, LANES - 1));
        else if (pick == 17) lanes = '0;
        else                 lanes = CW'($urandom_range(LANES + 1, (1 << CW) - 1));
        send_chunk(a_pos, a_neg, b_pos, b_neg, lanes, k == pair_len - 1);
        random_sent++;
      end
    end

    // Let every expected result drain, then idle before the summary.
    in_tvalid = 1'b0;
    in_tlast  = 1'b0;
    while (pending_dots != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("Sent %0d chunks and compared %0d dot products, %0d mismatches.",
             chunks_sent, dots_checked, mismatches);
    $display("Covered lane counts 0 to 63, mixed and malformed bit-planes and pairs of up to 30 chunks.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
